// File: rtl/ipv4_longest_prefix_match_top_macros.svh
// Assertion macros for the route lookup RTL.
`ifndef IPV4_LONGEST_PREFIX_MATCH_TOP_MACROS_SVH
`define IPV4_LONGEST_PREFIX_MATCH_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define LPM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("route lookup assertion failed");
`define LPM_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("route lookup reset assertion failed");
`else
`define LPM_ASSERT(lbl, clk, rst_n, prop)
`define LPM_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// File: rtl/ipv4_lpm_pkg.sv
// Shared types, constants and prefix-length functions for the route lookup.
package ipv4_lpm_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int PORTS_DEF   = 16;

    localparam int IP_W   = 32;
    localparam int IDX_W  = 4;
    localparam int PORT_W = 4;
    localparam int LEN_W  = 6;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [7:0] MASK_CODES [8] = '{
        8'd128, 8'd192, 8'd224, 8'd240, 8'd248, 8'd252, 8'd254, 8'd255
    };

    typedef struct packed {
        logic              hit;
        logic [PORT_W-1:0] port;
        logic [IDX_W-1:0]  idx;
        logic [LEN_W-1:0]  len;
    } t_best;

    // A byte counts 1..8 when it is one of the contiguous mask codes, else 0.
    function automatic logic [3:0] byte_prefix(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (b == MASK_CODES[i]) begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [LEN_W-1:0] mask_prefix(input logic [IP_W-1:0] m);
        return LEN_W'(byte_prefix(m[31:24])) + LEN_W'(byte_prefix(m[23:16]))
             + LEN_W'(byte_prefix(m[15:8]))  + LEN_W'(byte_prefix(m[7:0]));
    endfunction

endpackage

// File: rtl/ipv4_lpm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ipv4_lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ipv4_lpm_cmp.sv
// Shared match unit: tests one route per cycle while i_en is high and keeps the best so far.
module ipv4_lpm_cmp (
    input  logic                                 i_clk,
    input  logic                                 i_clr,
    input  logic                                 i_en,
    input  logic                                 i_route_valid,
    input  logic [ipv4_lpm_pkg::IP_W-1:0]        i_route_dest,
    input  logic [ipv4_lpm_pkg::IP_W-1:0]        i_route_mask,
    input  logic [ipv4_lpm_pkg::PORT_W-1:0]      i_route_port,
    input  logic [ipv4_lpm_pkg::IDX_W-1:0]       i_route_idx,
    input  logic [ipv4_lpm_pkg::IP_W-1:0]        i_addr,
    output ipv4_lpm_pkg::t_best                  o_best
);

    ipv4_lpm_pkg::t_best             r_best;
    ipv4_lpm_pkg::t_best             n_best;
    logic [ipv4_lpm_pkg::LEN_W-1:0]  len;
    logic                            match;

    assign len   = ipv4_lpm_pkg::mask_prefix(i_route_mask);
    assign match = i_route_valid
                && ((i_route_dest & i_route_mask) == (i_addr & i_route_mask));

    always_comb begin
        n_best = r_best;
        if (i_clr) begin
            n_best = '0;
        end else if (i_en && match && (!r_best.hit || (len > r_best.len))) begin
            n_best.hit  = 1'b1;
            n_best.port = i_route_port;
            n_best.idx  = i_route_idx;
            n_best.len  = len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
    end

    assign o_best = r_best;

endmodule

// File: rtl/ipv4_longest_prefix_match_top.sv
// Top level of the IPv4 longest-prefix-match route lookup.
//
// One command channel: a word is taken when i_start is high and o_busy is low.
// i_func selects the command. A write (func 0) loads the route in slot
// i_entry_index from i_entry_dest, i_entry_mask, i_entry_port and
// i_entry_valid in the accepting cycle; it gives no result and o_busy stays low.
// A write to a slot not below ENTRIES, or with a port not below PORTS, is dropped.
// A lookup (func 1) scans the table one slot per cycle through the route RAM
// and the shared match unit: ST_SCAN reads the route RAM, ST_LAST takes
// the last registered read into the match unit, and in ST_DONE the result
// shows on o_hit, o_out_port, o_match_index and o_prefix_len, marked by o_done
// for one cycle; o_busy is high from the cycle after acceptance through the
// o_done cycle, so the next word can be taken once the sequencer has returned
// to idle.
// The receiver cannot stall; results must be taken in the o_done cycle.
// On a tie the lowest slot wins; on a miss o_hit is low and the other result
// fields are zero.
// Reset (synchronous, active low) clears all route valid bits and returns the
// sequencer to idle; route contents stay undefined until written.
`include "ipv4_longest_prefix_match_top_macros.svh"
module ipv4_longest_prefix_match_top #(
    parameter int ENTRIES = ipv4_lpm_pkg::ENTRIES_DEF,
    parameter int PORTS   = ipv4_lpm_pkg::PORTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic                               i_func,
    input  logic [ipv4_lpm_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [ipv4_lpm_pkg::IP_W-1:0]      i_entry_dest,
    input  logic [ipv4_lpm_pkg::IP_W-1:0]      i_entry_mask,
    input  logic [ipv4_lpm_pkg::PORT_W-1:0]    i_entry_port,
    input  logic                               i_entry_valid,
    input  logic [ipv4_lpm_pkg::IP_W-1:0]      i_lookup_addr,
    output logic                               o_done,
    output logic                               o_hit,
    output logic [ipv4_lpm_pkg::PORT_W-1:0]    o_out_port,
    output logic [ipv4_lpm_pkg::IDX_W-1:0]     o_match_index,
    output logic [ipv4_lpm_pkg::LEN_W-1:0]     o_prefix_len
);

    localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WORD_W = 2 * ipv4_lpm_pkg::IP_W + ipv4_lpm_pkg::PORT_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_LAST = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state                            r_state, n_state;
    logic [AW-1:0]                     r_cnt, n_cnt;
    logic [AW-1:0]                     r_cmp_idx;
    logic                              r_cmp_en;
    logic                              r_cmp_valid;
    logic [ENTRIES-1:0]                r_valid;
    logic [ipv4_lpm_pkg::IP_W-1:0]     r_addr;

    logic                              accept;
    logic                              wr_ok;
    logic                              we;
    logic                              lookup_go;
    logic [AW-1:0]                     waddr;
    logic [WORD_W-1:0]                 wdata;
    logic [WORD_W-1:0]                 rdata;
    ipv4_lpm_pkg::t_best               best;

    assign accept    = i_start && (r_state == ST_IDLE);
    assign wr_ok     = (32'(i_entry_index) < ENTRIES) && (32'(i_entry_port) < PORTS);
    assign we        = accept && (i_func == ipv4_lpm_pkg::FUNC_WRITE) && wr_ok;
    assign lookup_go = accept && (i_func == ipv4_lpm_pkg::FUNC_LOOKUP);
    assign waddr     = AW'(i_entry_index);
    assign wdata     = {i_entry_dest, i_entry_mask, i_entry_port};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (lookup_go) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == AW'(ENTRIES - 1)) begin
                    n_state = ST_LAST;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_LAST: n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_cmp_en <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_cmp_en <= (r_state == ST_SCAN);
            if (we) begin
                r_valid[waddr] <= i_entry_valid;
            end
        end
    end

    // The compare index and valid bit are registered from r_cnt, in step with the registered RAM read data.
    always_ff @(posedge i_clk) begin
        r_cmp_idx   <= r_cnt;
        r_cmp_valid <= r_valid[r_cnt];
        if (lookup_go) begin
            r_addr <= i_lookup_addr;
        end
    end

    ipv4_lpm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_route_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_cnt),
        .o_rdata (rdata)
    );

    ipv4_lpm_cmp u_cmp (
        .i_clk         (i_clk),
        .i_clr         (lookup_go),
        .i_en          (r_cmp_en),
        .i_route_valid (r_cmp_valid),
        .i_route_dest  (rdata[WORD_W-1 -: ipv4_lpm_pkg::IP_W]),
        .i_route_mask  (rdata[ipv4_lpm_pkg::PORT_W +: ipv4_lpm_pkg::IP_W]),
        .i_route_port  (rdata[ipv4_lpm_pkg::PORT_W-1:0]),
        .i_route_idx   (ipv4_lpm_pkg::IDX_W'(r_cmp_idx)),
        .i_addr        (r_addr),
        .o_best        (best)
    );

    assign o_busy        = (r_state != ST_IDLE);
    assign o_done        = (r_state == ST_DONE);
    assign o_hit         = best.hit;
    assign o_out_port    = best.port;
    assign o_match_index = best.idx;
    assign o_prefix_len  = best.len;

    `LPM_ASSERT(a_done_single, i_clk, i_rst_n, o_done |=> !o_done)
    `LPM_ASSERT(a_miss_zero, i_clk, i_rst_n,
        (o_done && !o_hit) |-> (o_out_port == '0 && o_match_index == '0 && o_prefix_len == '0))
    `LPM_ASSERT(a_len_range, i_clk, i_rst_n, o_done |-> (o_prefix_len <= 6'd32))
    `LPM_ASSERT(a_latency, i_clk, i_rst_n,
        (i_start && !o_busy && i_func) |-> ##(ENTRIES + 2) o_done)
    `LPM_ASSERT_NR(a_reset_quiet, i_clk, !i_rst_n |=> !o_done)

endmodule
